// File: rtl/adaptive_burst_sender_assert.svh
// assertion macros for the adaptive burst sender
`ifndef ADAPTIVE_BURST_SENDER_ASSERT_SVH
`define ADAPTIVE_BURST_SENDER_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ABS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ABS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/abs_pkg.sv
// shared types, codes and helpers of the adaptive burst sender
package abs_pkg;

   localparam int unsigned NUM_W     = 16;
   localparam int unsigned IDX_W     = 6;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned BURST_CAP = 32;

   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   localparam logic [1:0] KIND_ACK = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_TAG   = 1'd1;

   localparam logic [7:0] FILL_BYTE = 8'h6b;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] pkt;
      logic [NUM_W-1:0] tag;
      logic [NUM_W-1:0] word;
   } csum_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] sum;
   } csum_rsp_type;

   function automatic logic [NUM_W-1:0] swap16(input logic [NUM_W-1:0] v);
      return {v[7:0], v[15:8]};
   endfunction

endpackage

// File: rtl/abs_req_if.sv
// request channel: op, ack number and ack kind with valid/ready
interface abs_req_if;
   import abs_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       op;
   logic [NUM_W-1:0] ack_number;
   logic [1:0]       ack_kind;

   modport source (output valid, output op, output ack_number, output ack_kind,
                   input ready);
   modport sink (input valid, input op, input ack_number, input ack_kind,
                 output ready);
endinterface

// File: rtl/abs_rsp_if.sv
// response channel: packet descriptors and the done marker with valid/ready
interface abs_rsp_if;
   import abs_pkg::*;

   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] packet_number;
   logic [IDX_W-1:0] burst_index;
   logic [IDX_W-1:0] window_field;
   logic [NUM_W-1:0] header_checksum;
   logic             last_of_burst;
   logic             transfer_done;

   modport source (output valid, output packet_number, output burst_index,
                   output window_field, output header_checksum,
                   output last_of_burst, output transfer_done, input ready);
   modport sink (input valid, input packet_number, input burst_index,
                 input window_field, input header_checksum,
                 input last_of_burst, input transfer_done, output ready);
endinterface

// File: rtl/adaptive_burst_sender.sv
// adaptive burst sender: top level with sequencer, state and output register
// sequence: a start item passes S_DESC, S_CSUM (shared checksum adder takes 3 steps)
//   and S_EMIT for each descriptor; S_EMIT waits while the output slot is full
// no new item is taken until a burst is done; an ack item passes S_ACK, a phase
//   end S_END_WIN and S_END_CHK before its first descriptor
// reset: synchronous, active high; idle phase, window and burst size at the
//   initial window, counts zero, total_packets 1, process_tag 0, no item pending
`include "adaptive_burst_sender_assert.svh"

module adaptive_burst_sender #(
   parameter int MAX_WINDOW     = 32,
   parameter int INITIAL_WINDOW = 4,
   parameter int PAYLOAD_BYTES  = 100
) (
   input  logic                           clock,
   input  logic                           reset,
   abs_req_if.sink                        req_chan,
   abs_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_en,
   input  logic [abs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [abs_pkg::NUM_W-1:0]      csr_wdata
);
   import abs_pkg::*;

   // window register must hold both the cap and the start value
   localparam int WIN_TOP = (MAX_WINDOW > INITIAL_WINDOW) ? MAX_WINDOW : INITIAL_WINDOW;
   localparam int WIN_W   = $clog2(WIN_TOP + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_ACK, S_END_WIN, S_END_CHK, S_DESC, S_CSUM, S_EMIT, S_DONE_OUT
   } state_type;

   typedef enum logic [1:0] {PH_IDLE, PH_RECV, PH_DONE} phase_type;

   // sequencer and session state
   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [NUM_W-1:0] acked_ff, acked_in;
   logic [NUM_W-1:0] gain_ff, gain_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic [IDX_W-1:0] burst_n_ff, burst_n_in;
   logic [IDX_W-1:0] seq_ff, seq_in;
   logic [NUM_W-1:0] pkt_ff, pkt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [1:0]       kind_ff, kind_in;

   // configuration
   logic [NUM_W-1:0] total_ff, total_in;
   logic [NUM_W-1:0] tag_ff, tag_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0] rsp_pkt_ff, rsp_pkt_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [IDX_W-1:0] rsp_win_ff, rsp_win_in;
   logic [NUM_W-1:0] rsp_csum_ff, rsp_csum_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_done_ff, rsp_done_in;

   // datapath helpers
   csum_req_type     csum_req;
   csum_rsp_type     csum_rsp;
   logic             slot_free;
   logic [NUM_W-1:0] half_gain;
   logic [NUM_W:0]   win_sum;
   logic [WIN_W-1:0] win_capped;
   logic [NUM_W-1:0] left;
   logic [NUM_W-1:0] win16;
   logic [NUM_W-1:0] n16;
   logic [IDX_W-1:0] n_capped;

   abs_csum #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_csum (
      .clock    (clock),
      .reset    (reset),
      .csum_req (csum_req),
      .csum_rsp (csum_rsp)
   );

   // header bit-field word maxburst | seq<<7, stored low byte first
   assign csum_req.start = (state_ff == S_DESC);
   assign csum_req.pkt   = pkt_ff;
   assign csum_req.tag   = tag_ff;
   assign csum_req.word  = swap16({2'b00, 7'(seq_ff), 7'(window_ff)});

   // window growth: half the gain rounded up, capped
   assign half_gain  = NUM_W'(({1'b0, gain_ff} + 17'd1) >> 1);
   assign win_sum    = (NUM_W + 1)'(window_ff) + {1'b0, half_gain};
   assign win_capped = (win_sum > (NUM_W + 1)'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                            : WIN_W'(win_sum);

   // next burst: min(window, packets left), never beyond the burst cap
   assign left     = total_ff - acked_ff;
   assign win16    = NUM_W'(window_ff);
   assign n16      = (win16 < left) ? win16 : left;
   assign n_capped = (n16 > NUM_W'(BURST_CAP)) ? IDX_W'(BURST_CAP) : IDX_W'(n16);

   // output slot may take a new item when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      acked_in     = acked_ff;
      gain_in      = gain_ff;
      window_in    = window_ff;
      burst_n_in   = burst_n_ff;
      seq_in       = seq_ff;
      pkt_in       = pkt_ff;
      num_in       = num_ff;
      kind_in      = kind_ff;
      total_in     = total_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pkt_in   = rsp_pkt_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_win_in   = rsp_win_ff;
      rsp_csum_in  = rsp_csum_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;

      // register writes only arrive while idle: the user must keep to this, the block itself does not enforce it
      if (csr_write_en) begin
         case (csr_index)
            CSR_TOTAL_PACKETS: total_in = csr_wdata;
            CSR_PROCESS_TAG:   tag_in   = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               num_in  = req_chan.ack_number;
               kind_in = req_chan.ack_kind;
               case (req_chan.op)
                  OP_START: begin
                     // a start is ignored while a session is receiving
                     if (phase_ff != PH_RECV) begin
                        acked_in   = '0;
                        gain_in    = '0;
                        window_in  = WIN_W'(INITIAL_WINDOW);
                        burst_n_in = IDX_W'(INITIAL_WINDOW);
                        seq_in     = IDX_W'(1);
                        pkt_in     = NUM_W'(1);
                        if (total_ff == '0) begin
                           state_in = S_DONE_OUT;
                        end else begin
                           phase_in = PH_RECV;
                           state_in = S_DESC;
                        end
                     end
                  end
                  OP_ACK: begin
                     if (phase_ff == PH_RECV) begin
                        state_in = S_ACK;
                     end
                  end
                  OP_TIMEOUT: begin
                     if (phase_ff == PH_RECV) begin
                        state_in = S_END_WIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_ACK: begin
            // cumulative ack: only a genuine ack above the count moves it
            if ((num_ff > acked_ff) && (kind_ff == KIND_ACK)) begin
               gain_in  = gain_ff + (num_ff - acked_ff);
               acked_in = num_ff;
            end
            // an ack naming the last packet closes the phase either way
            state_in = (num_ff == total_ff) ? S_END_WIN : S_IDLE;
         end

         S_END_WIN: begin
            window_in = win_capped;
            gain_in   = '0;
            state_in  = S_END_CHK;
         end

         S_END_CHK: begin
            if (acked_ff >= total_ff) begin
               state_in = S_DONE_OUT;
            end else begin
               burst_n_in = n_capped;
               seq_in     = IDX_W'(1);
               pkt_in     = acked_ff + NUM_W'(1);
               state_in   = S_DESC;
            end
         end

         S_DESC: begin
            // checksum unit is started this cycle
            state_in = S_CSUM;
         end

         S_CSUM: begin
            if (csum_rsp.done) begin
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pkt_in   = pkt_ff;
               rsp_idx_in   = seq_ff;
               rsp_win_in   = IDX_W'(window_ff);
               rsp_csum_in  = csum_rsp.sum;
               rsp_last_in  = (seq_ff == burst_n_ff);
               rsp_done_in  = 1'b0;
               if (seq_ff == burst_n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  seq_in   = seq_ff + IDX_W'(1);
                  pkt_in   = pkt_ff + NUM_W'(1);
                  state_in = S_DESC;
               end
            end
         end

         S_DONE_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pkt_in   = '0;
               rsp_idx_in   = '0;
               rsp_win_in   = '0;
               rsp_csum_in  = '0;
               rsp_last_in  = 1'b0;
               rsp_done_in  = 1'b1;
               phase_in     = PH_DONE;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         acked_ff     <= '0;
         gain_ff      <= '0;
         window_ff    <= WIN_W'(INITIAL_WINDOW);
         burst_n_ff   <= IDX_W'(INITIAL_WINDOW);
         total_ff     <= NUM_W'(1);
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         acked_ff     <= acked_in;
         gain_ff      <= gain_in;
         window_ff    <= window_in;
         burst_n_ff   <= burst_n_in;
         total_ff     <= total_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seq_ff      <= seq_in;
      pkt_ff      <= pkt_in;
      num_ff      <= num_in;
      kind_ff     <= kind_in;
      rsp_pkt_ff  <= rsp_pkt_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_win_ff  <= rsp_win_in;
      rsp_csum_ff <= rsp_csum_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   // new items only taken between sequences
   assign req_chan.ready = (state_ff == S_IDLE);

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.packet_number   = rsp_pkt_ff;
   assign rsp_chan.burst_index     = rsp_idx_ff;
   assign rsp_chan.window_field    = rsp_win_ff;
   assign rsp_chan.header_checksum = rsp_csum_ff;
   assign rsp_chan.last_of_burst   = rsp_last_ff;
   assign rsp_chan.transfer_done   = rsp_done_ff;

   // checks
   `ABS_ASSERT_SAME(a_done_clean, clock, reset, rsp_valid_ff && rsp_done_ff, (rsp_pkt_ff == '0) && (rsp_idx_ff == '0) && (rsp_win_ff == '0) && (rsp_csum_ff == '0) && !rsp_last_ff, "done item carries non-zero fields")
   `ABS_ASSERT_SAME(a_index_range, clock, reset, rsp_valid_ff && !rsp_done_ff, (rsp_idx_ff != '0) && (rsp_idx_ff <= IDX_W'(BURST_CAP)), "descriptor index outside burst range")
   `ABS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && !rsp_chan.ready, rsp_valid_ff && $stable({rsp_pkt_ff, rsp_idx_ff, rsp_win_ff, rsp_csum_ff, rsp_last_ff, rsp_done_ff}), "waiting item changed before it was taken")
   `ABS_ASSERT_NEXT(a_csum_owned, clock, reset, state_ff == S_DESC, state_ff == S_CSUM && !csum_rsp.done, "checksum unit out of step with sequencer")

endmodule

// File: rtl/abs_csum.sv
// shared ones'-complement adder that builds one header checksum over three steps
module abs_csum #(
   parameter int PAYLOAD_BYTES = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  abs_pkg::csum_req_type csum_req,
   output abs_pkg::csum_rsp_type csum_rsp
);
   import abs_pkg::*;

   // payload words are constant, folded to 16 bits at elaboration
   localparam int unsigned PAIRS    = PAYLOAD_BYTES / 2;
   localparam int unsigned PAY_RAW  = PAIRS * 32'({FILL_BYTE, FILL_BYTE})
                                      + (((PAYLOAD_BYTES % 2) != 0) ?
                                         32'({FILL_BYTE, 8'h00}) : 32'd0);
   localparam logic [NUM_W-1:0] PAY_FOLD = NUM_W'((PAY_RAW - 1) % 65535 + 1);

   typedef enum logic [1:0] {STEP_IDLE, STEP_PKT, STEP_TAG, STEP_WORD} step_type;

   step_type         step_ff, step_in;
   logic [NUM_W-1:0] acc_ff, acc_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] operand;
   logic [NUM_W:0]   wide_sum;
   logic [NUM_W-1:0] folded;

   always_comb begin
      case (step_ff)
         STEP_PKT:  operand = csum_req.pkt;
         STEP_TAG:  operand = csum_req.tag;
         STEP_WORD: operand = csum_req.word;
         default:   operand = '0;
      endcase
   end

   // end-around carry add
   assign wide_sum = {1'b0, acc_ff} + {1'b0, operand};
   assign folded   = wide_sum[NUM_W-1:0] + NUM_W'(wide_sum[NUM_W]);

   always_comb begin
      step_in = step_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (csum_req.start) begin
         step_in = STEP_PKT;
         acc_in  = PAY_FOLD;
      end else begin
         case (step_ff)
            STEP_PKT: begin
               acc_in  = folded;
               step_in = STEP_TAG;
            end
            STEP_TAG: begin
               acc_in  = folded;
               step_in = STEP_WORD;
            end
            STEP_WORD: begin
               acc_in  = folded;
               step_in = STEP_IDLE;
               done_in = 1'b1;
            end
            default: begin
               step_in = STEP_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
   end

   assign csum_rsp.done = done_ff;
   assign csum_rsp.sum  = swap16(~acc_ff);

endmodule
